FILE: hw/rtl/hts_pkg.sv
// Shared types, constants and codes of the HTML text stripper.
`timescale 1ns / 1ps
package hts_pkg;

    // Default width of the per-document emitted byte counter.
    localparam int COUNT_BITS_DEF = 16;

    // Reset value of the text limit register.
    localparam logic [15:0] MAX_TEXT_RESET = 16'd1023;

    // Configuration port.
    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;
    localparam logic REG_MAX_TEXT = 1'b0;   // register index, taken from paddr[2]

    // Job queue between front and back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

    // Characters of interest.
    localparam logic [7:0] CH_LT    = 8'h3C;   // <
    localparam logic [7:0] CH_GT    = 8'h3E;   // >
    localparam logic [7:0] CH_BANG  = 8'h21;   // !
    localparam logic [7:0] CH_DASH  = 8'h2D;   // -
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;

    // Class of one byte, settled by the front with its lookahead.
    typedef enum logic [2:0] {
        KIND_TEXT,       // visible unless inside markup
        KIND_WS,         // space, tab, LF or CR
        KIND_LT,         // open angle that starts a tag
        KIND_CMT_OPEN,   // open angle followed by "!--"
        KIND_CMT_CLOSE,  // dash followed by "->"
        KIND_GT,         // close angle
        KIND_TERM        // end of document, no byte
    } job_kind_t;

    typedef struct packed {
        job_kind_t   kind;
        logic [7:0]  data;
        logic        fin;    // byte decided in the final step of a document
    } job_t;

endpackage

FILE: hw/rtl/hts_in_if.sv
// Input stream channel: raw document bytes.
`timescale 1ns / 1ps
interface hts_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       doc_last;

    modport source (output valid, output in_byte, output doc_last, input ready);
    modport sink   (input valid, input in_byte, input doc_last, output ready);
endinterface

FILE: hw/rtl/hts_out_if.sv
// Output stream channel: extracted text bytes and end markers.
`timescale 1ns / 1ps
interface hts_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       has_byte;
    logic       end_of_text;

    modport source (output valid, output text_byte, output has_byte, output end_of_text,
                    input ready);
    modport sink   (input valid, input text_byte, input has_byte, input end_of_text,
                    output ready);
endinterface

FILE: hw/rtl/hts_front.sv
// Front end: lookahead window, comment delimiter detection and job generation.
`timescale 1ns / 1ps
module hts_front (
    input  logic          clk,
    input  logic          rst_n,
    hts_in_if.sink        in_ch,
    input  logic          q_full,
    output logic          q_push,
    output hts_pkg::job_t q_job
);
    import hts_pkg::*;

    logic [7:0] win_reg [0:3];
    logic [7:0] win_next [0:3];
    logic [2:0] fill_reg, fill_next;
    logic       flush_reg, flush_next;
    logic       acc;

    function automatic job_kind_t classify(input logic [7:0] b, input logic [7:0] la0,
                                           input logic [7:0] la1, input logic [7:0] la2,
                                           input logic [2:0] k);
        job_kind_t r;
        if (b == CH_LT) begin
            if (k >= 3'd3 && la0 == CH_BANG && la1 == CH_DASH && la2 == CH_DASH)
                r = KIND_CMT_OPEN;
            else
                r = KIND_LT;
        end else if (b == CH_DASH && k >= 3'd2 && la0 == CH_DASH && la1 == CH_GT) begin
            r = KIND_CMT_CLOSE;
        end else if (b == CH_GT) begin
            r = KIND_GT;
        end else if (b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_CR) begin
            r = KIND_WS;
        end else begin
            r = KIND_TEXT;
        end
        return r;
    endfunction

    assign in_ch.ready = !flush_reg && !q_full;
    assign acc = in_ch.valid && in_ch.ready;

    always_comb
    begin
        win_next   = win_reg;
        fill_next  = fill_reg;
        flush_next = flush_reg;
        q_push     = 1'b0;
        q_job      = '{kind: KIND_TERM, data: 8'd0, fin: 1'b1};

        if (flush_reg) begin
            // Drain the window at document end, lookahead shortened, then terminate.
            if (!q_full) begin
                q_push = 1'b1;
                if (fill_reg != 3'd0) begin
                    q_job = '{kind: classify(win_reg[0], win_reg[1], win_reg[2], win_reg[3],
                                             fill_reg - 3'd1),
                              data: win_reg[0], fin: 1'b1};
                    win_next[0] = win_reg[1];
                    win_next[1] = win_reg[2];
                    win_next[2] = win_reg[3];
                    win_next[3] = 8'd0;
                    fill_next   = fill_reg - 3'd1;
                end else begin
                    flush_next = 1'b0;
                end
            end
        end else if (acc) begin
            if (in_ch.doc_last) begin
                win_next[fill_reg[1:0]] = in_ch.in_byte;
                fill_next  = fill_reg + 3'd1;
                flush_next = 1'b1;
            end else if (fill_reg == 3'd3) begin
                // Full window: decide the oldest byte with three bytes of lookahead.
                q_push = 1'b1;
                q_job  = '{kind: classify(win_reg[0], win_reg[1], win_reg[2], in_ch.in_byte,
                                          3'd3),
                           data: win_reg[0], fin: 1'b0};
                win_next[0] = win_reg[1];
                win_next[1] = win_reg[2];
                win_next[2] = in_ch.in_byte;
            end else begin
                win_next[fill_reg[1:0]] = in_ch.in_byte;
                fill_next = fill_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            fill_reg  <= 3'd0;
            flush_reg <= 1'b0;
        end else begin
            fill_reg  <= fill_next;
            flush_reg <= flush_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
    end

endmodule

FILE: hw/rtl/hts_fifo.sv
// Small job queue between the front and back ends.
`timescale 1ns / 1ps
module hts_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  hts_pkg::job_t push_job,
    output logic          full,
    input  logic          pop,
    output logic          head_vld,
    output hts_pkg::job_t head_job
);
    import hts_pkg::*;

    job_t                    mem_reg [0:QUEUE_DEPTH-1];
    logic [QUEUE_PTR_BITS-1:0] wr_reg, rd_reg;
    logic [QUEUE_PTR_BITS:0]   cnt_reg;

    assign full     = (cnt_reg == (QUEUE_PTR_BITS + 1)'(QUEUE_DEPTH));
    assign head_vld = (cnt_reg != '0);
    assign head_job = mem_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push)
                wr_reg <= wr_reg + 1'b1;
            if (pop)
                rd_reg <= rd_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_job;
    end

endmodule

FILE: hw/rtl/hts_back.sv
// Back end: markup state, space folding, text limit and result beats.
`timescale 1ns / 1ps
module hts_back #(
    parameter int COUNT_BITS = hts_pkg::COUNT_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [15:0]   max_text,
    input  logic          q_vld,
    input  hts_pkg::job_t q_job,
    output logic          q_pop,
    hts_out_if.source     out_ch
);
    import hts_pkg::*;

    localparam logic [32:0] CNT_MASK = (33'd1 << COUNT_BITS) - 33'd1;

    logic [1:0]            skip_reg, skip_next;
    logic                  tag_reg, tag_next;
    logic                  cmt_reg, cmt_next;
    logic                  sp_reg, sp_next;
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;
    logic                  lim_reg, lim_next;
    logic                  sub_reg, sub_next;
    logic                  pend_vld_reg, pend_vld_next;
    logic [7:0]            pend_byte_reg, pend_byte_next;
    logic                  o_vld_reg, o_vld_next;
    logic [7:0]            o_byte_reg, o_byte_next;
    logic                  o_has_reg, o_has_next;
    logic                  o_end_reg, o_end_next;

    logic                  out_free;
    logic [32:0]           lim_wide;
    logic [COUNT_BITS-1:0] limit;
    logic                  do_text;
    logic                  beat_vld;
    logic [7:0]            beat_byte;

    // Limit saturates to the largest count the counter can hold.
    assign lim_wide = ({17'd0, max_text} > CNT_MASK) ? CNT_MASK : {17'd0, max_text};
    assign limit    = lim_wide[COUNT_BITS-1:0];
    assign out_free = !o_vld_reg || out_ch.ready;

    assign out_ch.valid       = o_vld_reg;
    assign out_ch.text_byte   = o_byte_reg;
    assign out_ch.has_byte    = o_has_reg;
    assign out_ch.end_of_text = o_end_reg;

    always_comb
    begin
        skip_next      = skip_reg;
        tag_next       = tag_reg;
        cmt_next       = cmt_reg;
        sp_next        = sp_reg;
        cnt_next       = cnt_reg;
        lim_next       = lim_reg;
        sub_next       = sub_reg;
        pend_vld_next  = pend_vld_reg;
        pend_byte_next = pend_byte_reg;
        o_vld_next     = o_vld_reg && !out_ch.ready;
        o_byte_next    = o_byte_reg;
        o_has_next     = o_has_reg;
        o_end_next     = o_end_reg;
        q_pop          = 1'b0;
        do_text        = 1'b0;
        beat_vld       = 1'b0;
        beat_byte      = 8'd0;

        if (q_vld) begin
            if (q_job.kind == KIND_TERM) begin
                if (out_free) begin
                    // Close the document: held beat carries the end flag, else empty marker.
                    q_pop       = 1'b1;
                    o_vld_next  = 1'b1;
                    o_byte_next = pend_vld_reg ? pend_byte_reg : 8'd0;
                    o_has_next  = pend_vld_reg;
                    o_end_next  = 1'b1;
                    skip_next     = 2'd0;
                    tag_next      = 1'b0;
                    cmt_next      = 1'b0;
                    sp_next       = 1'b0;
                    cnt_next      = '0;
                    lim_next      = 1'b0;
                    sub_next      = 1'b0;
                    pend_vld_next = 1'b0;
                end
            end else if (lim_reg) begin
                q_pop = 1'b1;
            end else if (skip_reg != 2'd0) begin
                q_pop     = 1'b1;
                skip_next = skip_reg - 2'd1;
            end else begin
                case (q_job.kind)
                    KIND_CMT_OPEN:
                    begin
                        q_pop     = 1'b1;
                        cmt_next  = 1'b1;
                        skip_next = 2'd3;
                    end
                    KIND_LT:
                    begin
                        q_pop    = 1'b1;
                        tag_next = 1'b1;
                    end
                    KIND_CMT_CLOSE:
                    begin
                        q_pop     = 1'b1;
                        cmt_next  = 1'b0;
                        sp_next   = 1'b1;
                        skip_next = 2'd2;
                    end
                    KIND_GT:
                    begin
                        if (tag_reg) begin
                            q_pop    = 1'b1;
                            tag_next = 1'b0;
                            sp_next  = 1'b1;
                        end else begin
                            do_text = 1'b1;
                        end
                    end
                    default:
                    begin
                        do_text = 1'b1;
                    end
                endcase

                if (do_text) begin
                    if (tag_reg || cmt_reg) begin
                        q_pop = 1'b1;
                    end else if (q_job.kind == KIND_WS) begin
                        q_pop   = 1'b1;
                        sp_next = 1'b1;
                    end else if (out_free) begin
                        if (cnt_reg >= limit) begin
                            // Limit hit: drop everything up to the end of the document.
                            q_pop    = 1'b1;
                            lim_next = 1'b1;
                            sub_next = 1'b0;
                        end else if (sp_reg && !sub_reg) begin
                            beat_vld  = 1'b1;
                            beat_byte = CH_SPACE;
                            cnt_next  = cnt_reg + COUNT_BITS'(1);
                            sub_next  = 1'b1;
                        end else begin
                            beat_vld  = 1'b1;
                            beat_byte = q_job.data;
                            cnt_next  = cnt_reg + COUNT_BITS'(1);
                            sp_next   = 1'b0;
                            sub_next  = 1'b0;
                            q_pop     = 1'b1;
                        end
                    end
                end
            end
        end

        // Final-step beats go through a hold register so the last one can take the end flag.
        if (beat_vld) begin
            if (q_job.fin) begin
                if (pend_vld_reg) begin
                    o_vld_next  = 1'b1;
                    o_byte_next = pend_byte_reg;
                    o_has_next  = 1'b1;
                    o_end_next  = 1'b0;
                end
                pend_vld_next  = 1'b1;
                pend_byte_next = beat_byte;
            end else begin
                o_vld_next  = 1'b1;
                o_byte_next = beat_byte;
                o_has_next  = 1'b1;
                o_end_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            skip_reg     <= 2'd0;
            tag_reg      <= 1'b0;
            cmt_reg      <= 1'b0;
            sp_reg       <= 1'b0;
            cnt_reg      <= '0;
            lim_reg      <= 1'b0;
            sub_reg      <= 1'b0;
            pend_vld_reg <= 1'b0;
            o_vld_reg    <= 1'b0;
        end else begin
            skip_reg     <= skip_next;
            tag_reg      <= tag_next;
            cmt_reg      <= cmt_next;
            sp_reg       <= sp_next;
            cnt_reg      <= cnt_next;
            lim_reg      <= lim_next;
            sub_reg      <= sub_next;
            pend_vld_reg <= pend_vld_next;
            o_vld_reg    <= o_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_byte_reg <= pend_byte_next;
        o_byte_reg    <= o_byte_next;
        o_has_reg     <= o_has_next;
        o_end_reg     <= o_end_next;
    end

endmodule

FILE: hw/rtl/html_text_stripper.sv
// Top level of the HTML text stripper: config register, front, job queue, back.
//
//  channel  | dir | beat                                   | accepted when
//  ---------+-----+----------------------------------------+---------------------------
//  in_ch    | in  | in_byte[7:0], doc_last                 | in_ch.valid & in_ch.ready
//  out_ch   | out | text_byte[7:0], has_byte, end_of_text  | out_ch.valid & out_ch.ready
//  apb      | in  | max_text_bytes at paddr 0 (16-bit)     | psel & penable & pwrite
//
// Flow: the front takes one input beat per cycle while the queue has room and no
//   drain is running; after a document's last beat it drains each buffered byte
//   and then closes the document. The back pops each dropped byte, emits each
//   visible character, and sends a pending space out first, ahead of the character.
// The four-entry job queue lets front and back stall independently; the output
//   register takes a new beat in the same cycle the old one is taken.
// Reset (rst_n, asynchronous, active low) clears the document state and loads
//   max_text_bytes with 1023.
`timescale 1ns / 1ps
module html_text_stripper #(
    parameter int COUNT_BITS = hts_pkg::COUNT_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    hts_in_if.sink                            in_ch,
    hts_out_if.source                         out_ch,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [hts_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [hts_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [hts_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                              pready
);
    import hts_pkg::*;

    logic [15:0] max_text_reg;
    logic        cfg_wr;
    logic        q_push, q_full, q_pop, q_vld;
    job_t        push_job, head_job;

    // Register file: one register, index taken from paddr[2]; low bits ignored.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_MAX_TEXT);
    assign prdata = (paddr[2] == REG_MAX_TEXT) ? {16'd0, max_text_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_text_reg <= MAX_TEXT_RESET;
        else if (cfg_wr)
            max_text_reg <= pwdata[15:0];
    end

    // Front: hold three bytes of lookahead, classify the oldest, push a job.
    hts_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .q_full (q_full),
        .q_push (q_push),
        .q_job  (push_job)
    );

    // Queue: decouple classification from emission.
    hts_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .head_vld (q_vld),
        .head_job (head_job)
    );

    // Back: track tags and comments, fold whitespace, enforce the limit, emit beats.
    hts_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .max_text (max_text_reg),
        .q_vld    (q_vld),
        .q_job    (head_job),
        .q_pop    (q_pop),
        .out_ch   (out_ch)
    );

endmodule
